FILE: hw/rtl/ctt_pkg.sv
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types and constants for the configuration text tokenizer.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_RES    = 3;
  localparam int RES_W      = $clog2(MAX_RES + 1);

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [2:0] TT_STRING  = 3'd0;
  localparam logic [2:0] TT_COMMA   = 3'd1;
  localparam logic [2:0] TT_ENDLINE = 3'd2;
  localparam logic [2:0] TT_LPAREN  = 3'd3;
  localparam logic [2:0] TT_RPAREN  = 3'd4;
  localparam logic [2:0] TT_LBRACE  = 3'd5;
  localparam logic [2:0] TT_RBRACE  = 3'd6;

  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_BARE    = 2'd1,
    MODE_QUOTED  = 2'd2,
    MODE_COMMENT = 2'd3
  } lex_mode_t;

  typedef struct packed {
    lex_mode_t mode;
    logic      quote_single;
    logic      escape_pending;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{mode: MODE_IDLE, quote_single: 1'b0,
                                       escape_pending: 1'b0};

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } byte_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [2:0] token_type;
    logic [7:0] char_value;
    logic       run_last;
  } token_t;

  function automatic token_t make_token(logic [1:0] kind, logic [2:0] ttype,
                                        logic [7:0] ch);
    token_t t;
    t.result_kind = kind;
    t.token_type  = ttype;
    t.char_value  = ch;
    t.run_last    = 1'b0;
    return t;
  endfunction

endpackage

FILE: hw/rtl/ctt_decode.sv
// ----------------------------------------------------------------------------
// ctt_decode
// Per-byte lexer step: next state and up to three result transactions.
// ----------------------------------------------------------------------------
module ctt_decode
  import ctt_pkg::*;
(
  input  lex_state_t                st,
  input  byte_t                     item,
  output lex_state_t                st_next,
  output token_t [MAX_RES-1:0]      res,
  output logic [RES_W-1:0]          res_count
);

  logic [7:0] b;
  logic       blank;
  logic       hash;
  logic       quote;
  logic       single_hit;
  logic [2:0] single_type;
  logic       ends_bare;
  logic [7:0] own_quote;
  logic       do_start;
  logic [RES_W-1:0] n;

  assign b = item.text_byte;

  always_comb begin
    blank     = b inside {CH_SPACE, CH_TAB, CH_CR};
    hash      = (b == CH_HASH);
    quote     = (b == CH_DQUOTE) || (b == CH_SQUOTE);
    own_quote = st.quote_single ? CH_SQUOTE : CH_DQUOTE;
    single_hit  = 1'b1;
    single_type = TT_STRING;
    case (b)
      CH_NL:     single_type = TT_ENDLINE;
      CH_COMMA:  single_type = TT_COMMA;
      CH_LPAREN: single_type = TT_LPAREN;
      CH_RPAREN: single_type = TT_RPAREN;
      CH_LBRACE: single_type = TT_LBRACE;
      CH_RBRACE: single_type = TT_RBRACE;
      default:   single_hit  = 1'b0;
    endcase
    ends_bare = hash || blank || single_hit || quote;
  end

  always_comb begin
    st_next  = st;
    res      = '0;
    n        = '0;
    do_start = 1'b0;

    case (st.mode)
      MODE_IDLE: do_start = 1'b1;
      MODE_BARE: begin
        if (ends_bare) begin
          res[n]       = make_token(KIND_DONE, TT_STRING, 8'd0);
          n            = n + 1'b1;
          st_next.mode = MODE_IDLE;
          do_start     = 1'b1;
        end else begin
          res[n] = make_token(KIND_CHAR, TT_STRING, b);
          n      = n + 1'b1;
        end
      end
      MODE_QUOTED: begin
        if (st.escape_pending) begin
          st_next.escape_pending = 1'b0;
          res[n] = make_token(KIND_CHAR, TT_STRING, b);
          n      = n + 1'b1;
        end else if (b == CH_BSLASH) begin
          st_next.escape_pending = 1'b1;
        end else if (b == own_quote) begin
          res[n]       = make_token(KIND_DONE, TT_STRING, 8'd0);
          n            = n + 1'b1;
          st_next.mode = MODE_IDLE;
        end else begin
          res[n] = make_token(KIND_CHAR, TT_STRING, b);
          n      = n + 1'b1;
        end
      end
      default: begin
        if (b == CH_NL) begin
          st_next.mode = MODE_IDLE;
        end
      end
    endcase

    if (do_start && !blank) begin
      if (hash) begin
        st_next.mode = MODE_COMMENT;
      end else if (single_hit) begin
        res[n] = make_token(KIND_DONE, single_type, 8'd0);
        n      = n + 1'b1;
      end else if (quote) begin
        st_next.mode           = MODE_QUOTED;
        st_next.quote_single   = (b == CH_SQUOTE);
        st_next.escape_pending = 1'b0;
      end else begin
        st_next.mode = MODE_BARE;
        res[n]       = make_token(KIND_CHAR, TT_STRING, b);
        n            = n + 1'b1;
      end
    end

    if (item.final_byte) begin
      if (st_next.mode == MODE_BARE || st_next.mode == MODE_QUOTED) begin
        res[n] = make_token(KIND_DONE, TT_STRING, 8'd0);
        n      = n + 1'b1;
      end
      res[n]  = make_token(KIND_END, TT_STRING, 8'd0);
      n       = n + 1'b1;
      st_next = LEX_RESET;
    end

    for (int i = 0; i < MAX_RES; i++) begin
      res[i].run_last = (RES_W'(i + 1) == n);
    end
  end

  assign res_count = n;

endmodule

FILE: hw/rtl/config_text_tokenizer.sv
// ----------------------------------------------------------------------------
// config_text_tokenizer
// Byte-stream lexer for configuration text, emitting token transactions.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel  (byte_valid / byte_stall / byte_data): one text byte per
//   transaction, final_byte marks the last byte of a stream.
//   token channel (token_valid / token_stall / token_data): result
//   transactions, run_last set on the last result caused by a byte.
// Each accepted byte is decoded in the cycle it is taken; its zero to three
// results enter an 8-entry result queue and appear on the token channel from
// the next cycle, one per cycle while token_stall is low.
// Throughput: one byte per cycle while bytes produce at most one result each
// and token_stall is low; the token channel drains one result per cycle, so
// bytes that produce two or three results hold back the input. byte_stall
// rises when the queue has fewer than three free entries.
// When the receiver stalls, the head result holds and the queue fills; input
// is then stalled. Reset empties the queue and returns the lexer to the
// between-tokens state; a final byte does the same for the lexer state.
// ----------------------------------------------------------------------------
module config_text_tokenizer
  import ctt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   byte_valid,
  output logic   byte_stall,
  input  byte_t  byte_data,
  output logic   token_valid,
  input  logic   token_stall,
  output token_t token_data
);

  lex_state_t              state;
  lex_state_t              state_next;
  token_t [MAX_RES-1:0]    res;
  logic [RES_W-1:0]        res_count;
  token_t                  fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [CNT_W-1:0]        count;
  logic                    accept;
  logic                    pop;
  logic [RES_W-1:0]        push_n;

  ctt_decode u_decode (
    .st        (state),
    .item      (byte_data),
    .st_next   (state_next),
    .res       (res),
    .res_count (res_count)
  );

  assign byte_stall  = (count > CNT_W'(FIFO_DEPTH - MAX_RES));
  assign accept      = byte_valid && !byte_stall;
  assign token_valid = (count != '0);
  assign pop         = token_valid && !token_stall;
  assign token_data  = fifo[rd_ptr];
  assign push_n      = accept ? res_count : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= LEX_RESET;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (accept && (RES_W'(i) < res_count)) begin
        fifo[wr_ptr + PTR_W'(i)] <= res[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_final_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_data.final_byte) |=>
      (state.mode == MODE_IDLE && !state.escape_pending && !state.quote_single))
    else $error("lexer state not cleared after final byte");

  a_escape_quoted: assert property (@(posedge clk) disable iff (rst)
    state.escape_pending |-> (state.mode == MODE_QUOTED))
    else $error("escape pending outside quoted string");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |->
      (count == $past(count) + CNT_W'($past(push_n)) - CNT_W'($past(pop))))
    else $error("result queue count mismatch");
`endif

endmodule

FILE: test/config_text_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_text_tokenizer_tb
// Feeds directed and random configuration text into the tokenizer with random
// idle and stall bursts plus one long token-side hold. A lexer model inside
// the bench predicts every token transaction, which is checked field by field.
// ----------------------------------------------------------------------------
module config_text_tokenizer_tb;
  import ctt_pkg::*;

  logic   clk;
  logic   rst;
  logic   byte_valid;
  logic   byte_stall;
  byte_t  byte_data;
  logic   token_valid;
  logic   token_stall;
  token_t token_data;

  token_t    expected_tokens[$];
  token_t    byte_tokens[$];
  token_t    exp_token;
  int        errors = 0;
  bit        idle_on = 1'b1;
  int        hold_len = 0;
  lex_mode_t lex_mode = MODE_IDLE;
  logic      quote_single = 1'b0;
  logic      esc_pending = 1'b0;

  config_text_tokenizer DUT (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data(byte_data),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token_data(token_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---- lexer model ----

  function automatic int single_token(logic [7:0] c);
    case (c)
      CH_NL:     return TT_ENDLINE;
      CH_COMMA:  return TT_COMMA;
      CH_LPAREN: return TT_LPAREN;
      CH_RPAREN: return TT_RPAREN;
      CH_LBRACE: return TT_LBRACE;
      CH_RBRACE: return TT_RBRACE;
      default:   return -1;
    endcase
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR;
  endfunction

  function automatic void push_token(logic [1:0] kind, logic [2:0] ttype, logic [7:0] ch);
    token_t t;
    t.result_kind = kind;
    t.token_type  = ttype;
    t.char_value  = ch;
    t.run_last    = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  function automatic void start_token(logic [7:0] c);
    int tt;
    tt = single_token(c);
    if (!is_blank(c)) begin
      if (c == CH_HASH) begin
        lex_mode = MODE_COMMENT;
      end else if (tt >= 0) begin
        push_token(KIND_DONE, 3'(tt), 8'h00);
      end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
        lex_mode     = MODE_QUOTED;
        quote_single = (c == CH_SQUOTE);
        esc_pending  = 1'b0;
      end else begin
        lex_mode = MODE_BARE;
        push_token(KIND_CHAR, TT_STRING, c);
      end
    end
  endfunction

  function automatic void tokenize_byte(byte_t bt);
    logic [7:0] c;
    logic [7:0] own_quote;
    token_t     t;
    c = bt.text_byte;
    byte_tokens.delete();
    case (lex_mode)
      MODE_IDLE: start_token(c);
      MODE_BARE: begin
        if (is_blank(c) || c == CH_HASH || single_token(c) >= 0 ||
            c == CH_DQUOTE || c == CH_SQUOTE) begin
          push_token(KIND_DONE, TT_STRING, 8'h00);
          lex_mode = MODE_IDLE;
          start_token(c);
        end else begin
          push_token(KIND_CHAR, TT_STRING, c);
        end
      end
      MODE_QUOTED: begin
        own_quote = quote_single ? CH_SQUOTE : CH_DQUOTE;
        if (esc_pending) begin
          esc_pending = 1'b0;
          push_token(KIND_CHAR, TT_STRING, c);
        end else if (c == CH_BSLASH) begin
          esc_pending = 1'b1;
        end else if (c == own_quote) begin
          push_token(KIND_DONE, TT_STRING, 8'h00);
          lex_mode = MODE_IDLE;
        end else begin
          push_token(KIND_CHAR, TT_STRING, c);
        end
      end
      default: begin
        if (c == CH_NL) lex_mode = MODE_IDLE;
      end
    endcase
    if (bt.final_byte) begin
      if (lex_mode == MODE_BARE || lex_mode == MODE_QUOTED)
        push_token(KIND_DONE, TT_STRING, 8'h00);
      push_token(KIND_END, TT_STRING, 8'h00);
      lex_mode     = MODE_IDLE;
      quote_single = 1'b0;
      esc_pending  = 1'b0;
    end
    if (byte_tokens.size() > 0) begin
      t = byte_tokens.pop_back();
      t.run_last = 1'b1;
      byte_tokens.push_back(t);
    end
    foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endfunction

  // ---- byte side ----

  task automatic byte_gap(int n);
    repeat (n) begin
      @(negedge clk);
      byte_valid <= 1'b0;
    end
  endtask

  task automatic send_byte(logic [7:0] c, logic fin);
    byte_t bt;
    bt.text_byte  = c;
    bt.final_byte = fin;
    if (idle_on && $urandom_range(0, 4) == 0) byte_gap($urandom_range(1, 4));
    @(negedge clk);
    byte_valid <= 1'b1;
    byte_data  <= bt;
    do @(posedge clk); while (byte_stall);
    tokenize_byte(bt);
  endtask

  task automatic send_text(string s, logic fin_at_end);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], fin_at_end && (i == s.len() - 1));
  endtask

  task automatic wait_for_results();
    byte_gap(1);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 48) begin
      case ($urandom_range(0, 2))
        0:       return CH_SPACE;
        1:       return CH_TAB;
        default: return CH_CR;
      endcase
    end
    if (r < 64) begin
      case ($urandom_range(0, 5))
        0:       return CH_NL;
        1:       return CH_COMMA;
        2:       return CH_LPAREN;
        3:       return CH_RPAREN;
        4:       return CH_LBRACE;
        default: return CH_RBRACE;
      endcase
    end
    if (r < 72) return $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
    if (r < 78) return CH_BSLASH;
    if (r < 83) return CH_HASH;
    return 8'($urandom_range(0, 255));
  endfunction

  // ---- tests ----

  task automatic test_delimiters();
    send_text("\t (){},\r\n", 1'b0);
  endtask

  task automatic test_bare_words();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_SPACE, 1'b0);
  endtask

  // '#' ending a word opens a comment; its newline yields no endline token
  task automatic test_comments();
    send_text("x#y\n", 1'b0);
  endtask

  // other quote is plain, escaped own quote and escaped backslash, empty string
  task automatic test_quoted_strings();
    send_text("k'\"\\'\\\\'", 1'b0);
    send_text("\"\"", 1'b0);
  endtask

  task automatic test_final_byte();
    send_text("ab", 1'b1);
    send_text("'\\", 1'b1);
    send_byte(CH_HASH, 1'b1);
  endtask

  task automatic test_backpressure();
    int i;
    hold_len = 40;
    for (i = 0; i < 20; i++) send_byte(8'h61 + i[7:0], 1'b0);
    send_byte(CH_COMMA, 1'b1);
    wait_for_results();
  endtask

  task automatic test_random_text(int n);
    repeat (n) send_byte(pick_text_byte(), $urandom_range(0, 39) == 0);
  endtask

  // ---- token side ----

  initial begin : token_stall_gen
    int burst;
    token_stall = 1'b0;
    forever begin
      if (hold_len > 0) begin
        burst    = hold_len;
        hold_len = 0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 4);
      end else begin
        burst = 0;
      end
      if (burst > 0) begin
        repeat (burst) begin
          @(negedge clk);
          token_stall <= 1'b1;
        end
      end else begin
        @(negedge clk);
        token_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && token_valid && !token_stall) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %h", $time, token_data);
        errors++;
      end else begin
        exp_token = expected_tokens.pop_front();
        if (token_data.result_kind !== exp_token.result_kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $time,
                   exp_token.result_kind, token_data.result_kind);
          errors++;
        end
        if (token_data.token_type !== exp_token.token_type) begin
          $display("%0t: token_type expected %0d actual %0d", $time,
                   exp_token.token_type, token_data.token_type);
          errors++;
        end
        if (token_data.char_value !== exp_token.char_value) begin
          $display("%0t: char_value expected %h actual %h", $time,
                   exp_token.char_value, token_data.char_value);
          errors++;
        end
        if (token_data.run_last !== exp_token.run_last) begin
          $display("%0t: run_last expected %b actual %b", $time,
                   exp_token.run_last, token_data.run_last);
          errors++;
        end
      end
    end
  end

  // ---- sequence ----

  initial begin
    rst        = 1'b1;
    byte_valid = 1'b0;
    byte_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_delimiters();
    test_bare_words();
    test_comments();
    test_quoted_strings();
    test_final_byte();
    test_backpressure();
    test_random_text(100);
    wait_for_results();
    idle_on = 1'b0;
    test_random_text(30);

    wait_for_results();
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
